// ===== hdl/ffsa_pkg.sv =====
// Package for the first-fit segment allocator.
// Holds the table sizes, field widths, status codes and the command and
// status bundles between the controller and the datapath. No dependencies.
`timescale 1ns / 1ps

package ffsa_pkg;

  // Table depth and address width of the managed memory.
  localparam int MAX_SEGMENTS = 16;
  localparam int ADDR_WIDTH   = 16;

  // Derived widths.
  localparam int IDX_W   = $clog2(MAX_SEGMENTS);
  localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int MSIZE_W = ADDR_WIDTH + 1;

  // Fixed field widths.
  localparam int REQ_W  = 17;
  localparam int ID_W   = 16;
  localparam int CFG_W  = 17;
  localparam int STAT_W = 2;

  // Wide scratch width for size compares and saturation.
  localparam int WIDE_W = 34;

  // Request modes.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_HOLE   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new request
    logic step;    // advance the scan by one table entry
    logic insert;  // open a slot at the scan position and write the segment
    logic remove;  // close up the table over the scan position
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode;     // mode of the request in progress
    logic full;     // table holds MAX_SEGMENTS entries
    logic zero_req; // allocate request of zero words
    logic at_end;   // scan position equals the entry count
    logic fit;      // gap below the scan position holds the request
    logic match;    // entry at the scan position has the requested owner
  } sts_t;

endpackage

// ===== hdl/first_fit_segment_allocator.sv =====
// First-fit segment allocator, top level. An accepted beat is captured, then
// the scan steps over one table entry per cycle, the table is updated on an
// insert or a remove, and the result is loaded into the output register. One
// request is in work at a time: the next beat is taken only once the block is
// back in its idle state after the result is loaded.
// Synchronous reset empties the table, clears the id counter, sets 65536 words.
`timescale 1ns / 1ps

module first_fit_segment_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [ffsa_pkg::REQ_W-1:0]    request_size,
  input  logic [ffsa_pkg::ID_W-1:0]     free_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ffsa_pkg::STAT_W-1:0]   status,
  input  logic                          cfg_write,
  input  logic [ffsa_pkg::CFG_W-1:0]    cfg_data
);

  ffsa_pkg::cmd_t cmd;
  ffsa_pkg::sts_t sts;

  // Request sequencing and result beat.
  ffsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Segment table and gap arithmetic.
  ffsa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_mode   (mode),
    .in_req    (request_size),
    .in_id     (free_id),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== hdl/ffsa_dp.sv =====
// Datapath of the first-fit segment allocator: segment table, scan
// position, gap arithmetic, id counter and the memory size register.
// Depends on ffsa_pkg.
`timescale 1ns / 1ps

module ffsa_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  ffsa_pkg::cmd_t                  cmd,
  output ffsa_pkg::sts_t                  sts,
  input  logic                            in_mode,
  input  logic [ffsa_pkg::REQ_W-1:0]      in_req,
  input  logic [ffsa_pkg::ID_W-1:0]       in_id,
  input  logic                            cfg_write,
  input  logic [ffsa_pkg::CFG_W-1:0]      cfg_data
);

  // Segment table, kept in address order.
  logic [ffsa_pkg::ADDR_WIDTH-1:0] seg_first [ffsa_pkg::MAX_SEGMENTS];
  logic [ffsa_pkg::ADDR_WIDTH-1:0] seg_last  [ffsa_pkg::MAX_SEGMENTS];
  logic [ffsa_pkg::ID_W-1:0]       seg_owner [ffsa_pkg::MAX_SEGMENTS];

  logic [ffsa_pkg::CNT_W-1:0]   seg_count;
  logic [ffsa_pkg::ID_W-1:0]    id_counter;
  logic [ffsa_pkg::MSIZE_W-1:0] mem_size;

  // Request in progress and scan state.
  logic                         req_mode;
  logic [ffsa_pkg::REQ_W-1:0]   req_size;
  logic [ffsa_pkg::ID_W-1:0]    req_id;
  logic [ffsa_pkg::CNT_W-1:0]   idx;
  logic [ffsa_pkg::MSIZE_W-1:0] lo;

  logic [ffsa_pkg::IDX_W-1:0]   rd_idx;
  logic                         in_table;
  logic [ffsa_pkg::MSIZE_W-1:0] hi;
  logic [ffsa_pkg::MSIZE_W:0]   gap;
  logic [ffsa_pkg::WIDE_W-1:0]  new_last;
  logic [ffsa_pkg::WIDE_W-1:0]  cfg_wide;
  logic [ffsa_pkg::WIDE_W-1:0]  size_limit;

  // Entry under the scan position and the gap that ends there.
  assign rd_idx   = idx[ffsa_pkg::IDX_W-1:0];
  assign in_table = (idx < seg_count);
  assign hi       = in_table ? {1'b0, seg_first[rd_idx]} : mem_size;
  assign gap      = {1'b0, hi} - {1'b0, lo};
  assign new_last = ffsa_pkg::WIDE_W'(lo) + ffsa_pkg::WIDE_W'(req_size)
                    - ffsa_pkg::WIDE_W'(1);

  // Status toward the controller.
  always_comb begin
    sts.mode     = req_mode;
    sts.full     = (seg_count == ffsa_pkg::CNT_W'(ffsa_pkg::MAX_SEGMENTS));
    sts.zero_req = (req_size == '0);
    sts.at_end   = !in_table;
    sts.fit      = !gap[ffsa_pkg::MSIZE_W] &&
                   (ffsa_pkg::WIDE_W'(gap[ffsa_pkg::MSIZE_W-1:0]) >=
                    ffsa_pkg::WIDE_W'(req_size));
    sts.match    = in_table && (seg_owner[rd_idx] == req_id);
  end

  // Memory size writes saturate at the size of the address space.
  assign cfg_wide   = ffsa_pkg::WIDE_W'(cfg_data);
  assign size_limit = ffsa_pkg::WIDE_W'(1) << ffsa_pkg::ADDR_WIDTH;

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_size <= ffsa_pkg::MSIZE_W'(size_limit);
    end else if (cfg_write) begin
      mem_size <= (cfg_wide > size_limit) ? ffsa_pkg::MSIZE_W'(size_limit)
                                          : ffsa_pkg::MSIZE_W'(cfg_wide);
    end
  end

  // Request capture, scan position and id counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      id_counter <= '0;
    end else if (cmd.load && (in_mode == ffsa_pkg::MODE_ALLOC)) begin
      id_counter <= id_counter + 1'b1;
    end
    if (cmd.load) begin
      req_mode <= in_mode;
      req_size <= in_req;
      req_id   <= in_id;
      idx      <= '0;
      lo       <= '0;
    end else if (cmd.step) begin
      idx <= idx + 1'b1;
      lo  <= {1'b0, seg_last[rd_idx]} + 1'b1;
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count <= '0;
    end else if (cmd.insert) begin
      seg_count <= seg_count + 1'b1;
    end else if (cmd.remove) begin
      seg_count <= seg_count - 1'b1;
    end
  end

  // Table update: entries from the scan position up move to or from a neighbor.
  always_ff @(posedge clk) begin
    for (int k = 0; k < ffsa_pkg::MAX_SEGMENTS; k++) begin
      if (cmd.insert) begin
        if (ffsa_pkg::CNT_W'(k) == idx) begin
          seg_first[k] <= ffsa_pkg::ADDR_WIDTH'(lo);
          seg_last[k]  <= ffsa_pkg::ADDR_WIDTH'(new_last);
          seg_owner[k] <= id_counter;
        end else if ((k > 0) && (ffsa_pkg::CNT_W'(k) > idx)) begin
          seg_first[k] <= seg_first[(k > 0) ? k - 1 : 0];
          seg_last[k]  <= seg_last[(k > 0) ? k - 1 : 0];
          seg_owner[k] <= seg_owner[(k > 0) ? k - 1 : 0];
        end
      end else if (cmd.remove) begin
        if ((k < ffsa_pkg::MAX_SEGMENTS - 1) && (ffsa_pkg::CNT_W'(k) >= idx)) begin
          seg_first[k] <= seg_first[(k < ffsa_pkg::MAX_SEGMENTS - 1) ? k + 1 : k];
          seg_last[k]  <= seg_last[(k < ffsa_pkg::MAX_SEGMENTS - 1) ? k + 1 : k];
          seg_owner[k] <= seg_owner[(k < ffsa_pkg::MAX_SEGMENTS - 1) ? k + 1 : k];
        end
      end
    end
  end

endmodule

// ===== hdl/ffsa_ctrl.sv =====
// Controller of the first-fit segment allocator: request sequencing and
// the result register on the output channel.
// Depends on ffsa_pkg.
`timescale 1ns / 1ps

module ffsa_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ffsa_pkg::STAT_W-1:0]   status,
  output ffsa_pkg::cmd_t                cmd,
  input  ffsa_pkg::sts_t                sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_INSERT,
    S_REMOVE,
    S_REPLY
  } state_t;

  state_t                      state;
  state_t                      state_next;
  logic [ffsa_pkg::STAT_W-1:0] res;
  logic [ffsa_pkg::STAT_W-1:0] res_next;
  logic                        slot_free;

  // A new beat is taken only between requests.
  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  // Next state, result code and datapath commands.
  always_comb begin
    state_next = state;
    res_next   = res;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.mode == ffsa_pkg::MODE_ALLOC) begin
          if (sts.full) begin
            res_next   = ffsa_pkg::ST_FULL;
            state_next = S_REPLY;
          end else if (sts.zero_req) begin
            res_next   = ffsa_pkg::ST_NO_HOLE;
            state_next = S_REPLY;
          end else if (sts.fit) begin
            state_next = S_INSERT;
          end else if (sts.at_end) begin
            res_next   = ffsa_pkg::ST_NO_HOLE;
            state_next = S_REPLY;
          end else begin
            cmd.step = 1'b1;
          end
        end else begin
          if (sts.at_end) begin
            res_next   = ffsa_pkg::ST_NOT_FOUND;
            state_next = S_REPLY;
          end else if (sts.match) begin
            state_next = S_REMOVE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        res_next   = ffsa_pkg::ST_OK;
        state_next = S_REPLY;
      end
      S_REMOVE: begin
        cmd.remove = 1'b1;
        res_next   = ffsa_pkg::ST_OK;
        state_next = S_REPLY;
      end
      S_REPLY: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      res   <= res_next;
      if ((state == S_REPLY) && slot_free) begin
        out_valid <= 1'b1;
        status    <= res;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the first-fit segment allocator.
// It drives allocate and free beats, predicts each status, and checks every result beat.
// It depends on ffsa_pkg and first_fit_segment_allocator in the hdl folder.
`timescale 1ns / 1ps

module tb;

  localparam int STALL_MAX      = 17;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = ffsa_pkg::MAX_SEGMENTS + 8;
  localparam int PHASE_BEATS    = 72;
  localparam int NUM_PHASES     = 12;
  localparam longint ADDR_SPAN  = 64'd1 << ffsa_pkg::ADDR_WIDTH;

  // Segment table predictor and store of expected status beats.
  class segment_scoreboard;
    logic [ffsa_pkg::ADDR_WIDTH-1:0] seg_first [ffsa_pkg::MAX_SEGMENTS];
    logic [ffsa_pkg::ADDR_WIDTH-1:0] seg_last  [ffsa_pkg::MAX_SEGMENTS];
    logic [ffsa_pkg::ID_W-1:0]       seg_owner [ffsa_pkg::MAX_SEGMENTS];
    int unsigned                     seg_count;
    logic [ffsa_pkg::ID_W-1:0]       next_id;
    logic [ffsa_pkg::MSIZE_W-1:0]    mem_words;
    logic [ffsa_pkg::STAT_W-1:0]     status_q [$];
    int unsigned                     errors;

    function new();
      seg_count = 0;
      next_id   = '0;
      mem_words = ffsa_pkg::MSIZE_W'(65536);
      errors    = 0;
    endfunction

    // Writes above the address span saturate; zero is kept as is.
    function void set_memory_size(logic [ffsa_pkg::CFG_W-1:0] words);
      if (longint'(words) > ADDR_SPAN) mem_words = ffsa_pkg::MSIZE_W'(ADDR_SPAN);
      else mem_words = ffsa_pkg::MSIZE_W'(words);
    endfunction

    // First fit: the id advances even when the request fails.
    function logic [ffsa_pkg::STAT_W-1:0] alloc_segment(logic [ffsa_pkg::REQ_W-1:0] want);
      longint lo, hi;
      int unsigned pos, k;
      next_id = next_id + 1'b1;
      if (seg_count >= ffsa_pkg::MAX_SEGMENTS) return ffsa_pkg::ST_FULL;
      if (want == '0) return ffsa_pkg::ST_NO_HOLE;
      lo = 0;
      for (pos = 0; pos <= seg_count; pos++) begin
        hi = (pos < seg_count) ? longint'(seg_first[pos]) : longint'(mem_words);
        // A gap that comes out negative holds no free words.
        if (hi - lo > 0 && hi - lo >= longint'(want)) begin
          for (k = seg_count; k > pos; k--) begin
            seg_first[k] = seg_first[k-1];
            seg_last[k]  = seg_last[k-1];
            seg_owner[k] = seg_owner[k-1];
          end
          seg_first[pos] = lo[ffsa_pkg::ADDR_WIDTH-1:0];
          seg_last[pos]  = ffsa_pkg::ADDR_WIDTH'(lo + longint'(want) - 1);
          seg_owner[pos] = next_id;
          seg_count++;
          return ffsa_pkg::ST_OK;
        end
        if (pos < seg_count) lo = longint'(seg_last[pos]) + 1;
      end
      return ffsa_pkg::ST_NO_HOLE;
    endfunction

    // The lowest-address entry with a matching owner is removed.
    function logic [ffsa_pkg::STAT_W-1:0] free_segment(logic [ffsa_pkg::ID_W-1:0] owner);
      int unsigned pos, k;
      if (seg_count == 0) return ffsa_pkg::ST_NOT_FOUND;
      for (pos = 0; pos < seg_count; pos++)
        if (seg_owner[pos] == owner) break;
      if (pos >= seg_count) return ffsa_pkg::ST_NOT_FOUND;
      for (k = pos; k + 1 < seg_count; k++) begin
        seg_first[k] = seg_first[k+1];
        seg_last[k]  = seg_last[k+1];
        seg_owner[k] = seg_owner[k+1];
      end
      seg_count--;
      return ffsa_pkg::ST_OK;
    endfunction

    function void note_request(logic m, logic [ffsa_pkg::REQ_W-1:0] words,
                               logic [ffsa_pkg::ID_W-1:0] owner);
      if (m == ffsa_pkg::MODE_ALLOC) status_q.push_back(alloc_segment(words));
      else status_q.push_back(free_segment(owner));
    endfunction

    function void check_status(logic [ffsa_pkg::STAT_W-1:0] actual);
      logic [ffsa_pkg::STAT_W-1:0] expected;
      if (status_q.size() == 0) begin
        $error("status: no beat expected, actual %0d", actual);
        errors++;
        return;
      end
      // Oldest expected beat comes first.
      expected = status_q[0];
      status_q.delete(0);
      if (actual !== expected) begin
        $error("status: expected %0d, actual %0d", expected, actual);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return status_q.size();
    endfunction

    // Owner of a random live segment, so that most frees hit.
    function logic [ffsa_pkg::ID_W-1:0] live_owner();
      if (seg_count == 0) return ffsa_pkg::ID_W'($urandom);
      return seg_owner[$urandom_range(seg_count - 1, 0)];
    endfunction

    function void final_check();
      if (status_q.size() != 0) begin
        $error("status: %0d expected beats never arrived", status_q.size());
        errors++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst          = 1'b1;
  logic                          in_valid     = 1'b0;
  logic                          in_stall;
  logic                          mode         = ffsa_pkg::MODE_ALLOC;
  logic [ffsa_pkg::REQ_W-1:0]    request_size = '0;
  logic [ffsa_pkg::ID_W-1:0]     free_id      = '0;
  logic                          out_valid;
  logic                          out_stall    = 1'b0;
  logic [ffsa_pkg::STAT_W-1:0]   status;
  logic                          cfg_write    = 1'b0;
  logic [ffsa_pkg::CFG_W-1:0]    cfg_data     = '0;

  segment_scoreboard sb;
  bit          src_gaps      = 1'b1;
  bit          sink_gaps     = 1'b1;
  bit          long_hold_due = 1'b0;
  int unsigned quiet_cycles  = 0;
  int unsigned phase_sizes [NUM_PHASES] =
    '{131071, 0, 1, 48, 600, 65536, 100000, 200, 16, 5000, 64, 2};

  first_fit_segment_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .request_size (request_size),
    .free_id      (free_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Note accepted beats on both sides and watch for a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_request(mode, request_size, free_id);
      if (out_valid && !out_stall) sb.check_status(status);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Result side: a random hold before each beat, or one long hold on request.
  initial begin : result_sink
    int unsigned hold;
    forever begin
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        hold = LONG_HOLD;
      end else begin
        hold = sink_gaps ? $urandom_range(0, STALL_MAX) : 0;
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one beat after a random gap and wait until it is taken.
  task automatic send_beat(input logic m, input logic [ffsa_pkg::REQ_W-1:0] words,
                           input logic [ffsa_pkg::ID_W-1:0] owner);
    int unsigned gap;
    gap = src_gaps ? $urandom_range(0, STALL_MAX) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    request_size <= words;
    free_id      <= owner;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic stop_source();
    in_valid <= 1'b0;
  endtask

  // The first wait lets the monitor record a beat taken at this edge.
  task automatic wait_drained();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // The size register is only written with the block idle.
  task automatic write_memory_size(input logic [ffsa_pkg::CFG_W-1:0] words);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= words;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_memory_size(words);
  endtask

  // Empty-table free, zero and oversize requests, whole-memory fit,
  // full table, unknown id, and refilling freed holes.
  task automatic run_directed();
    send_beat(ffsa_pkg::MODE_FREE, '0, '0);
    send_beat(ffsa_pkg::MODE_ALLOC, '0, '0);
    send_beat(ffsa_pkg::MODE_ALLOC, 17'd65536, '0);
    send_beat(ffsa_pkg::MODE_ALLOC, 17'd1, '0);
    send_beat(ffsa_pkg::MODE_ALLOC, 17'h1FFFF, '0);
    send_beat(ffsa_pkg::MODE_FREE, '0, 16'hFFFF);
    send_beat(ffsa_pkg::MODE_FREE, '0, 16'd2);
    repeat (ffsa_pkg::MAX_SEGMENTS) send_beat(ffsa_pkg::MODE_ALLOC, 17'd1, '0);
    send_beat(ffsa_pkg::MODE_ALLOC, 17'd1, '0);
    send_beat(ffsa_pkg::MODE_FREE, '0, 16'd12);
    send_beat(ffsa_pkg::MODE_FREE, '0, 16'd5);
    send_beat(ffsa_pkg::MODE_ALLOC, 17'd1, '0);
    send_beat(ffsa_pkg::MODE_ALLOC, 17'd1, '0);
  endtask

  // Mostly well-sized allocates and frees of live owners, with some noise.
  task automatic run_random_phase(input logic [ffsa_pkg::CFG_W-1:0] words,
                                  input bit squeeze);
    int unsigned i, pick, span;
    logic [ffsa_pkg::REQ_W-1:0] want;
    stop_source();
    write_memory_size(words);
    src_gaps  = ($urandom_range(0, 3) != 0);
    sink_gaps = ($urandom_range(0, 3) != 0);
    if (squeeze) begin
      src_gaps      = 1'b0;
      long_hold_due = 1'b1;
    end
    span = (sb.mem_words > 6) ? int'(sb.mem_words) / 6 : 1;
    for (i = 0; i < PHASE_BEATS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 52) begin
        case ($urandom_range(0, 19))
          0:       want = '0;
          1:       want = ffsa_pkg::REQ_W'($urandom_range(0, 131071));
          2:       want = ffsa_pkg::REQ_W'(int'(sb.mem_words) + $urandom_range(0, 3));
          default: want = ffsa_pkg::REQ_W'($urandom_range(1, span));
        endcase
        send_beat(ffsa_pkg::MODE_ALLOC, want, ffsa_pkg::ID_W'($urandom));
      end else if (pick < 90) begin
        send_beat(ffsa_pkg::MODE_FREE, ffsa_pkg::REQ_W'($urandom), sb.live_owner());
      end else begin
        send_beat(ffsa_pkg::MODE_FREE, ffsa_pkg::REQ_W'($urandom),
                  ffsa_pkg::ID_W'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    int unsigned p;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    // The fifth phase also holds the result side off for a long stretch.
    for (p = 0; p < NUM_PHASES; p++)
      run_random_phase(ffsa_pkg::CFG_W'(phase_sizes[p]), p == 4);
    stop_source();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.final_check();
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ffsa_pkg.sv
hdl/ffsa_dp.sv
hdl/ffsa_ctrl.sv
hdl/first_fit_segment_allocator.sv
verif/tb.sv
